// ----- hdl/ptst_pkg.sv -----
// Shared types, codes and default sizes of the priority task slot table.
`timescale 1ns / 1ps
package ptst_pkg;

    // Default group counts per level and slots per group.
    localparam int unsigned P_LEVEL0_GROUPS   = 2;
    localparam int unsigned P_LEVEL1_GROUPS   = 2;
    localparam int unsigned P_LEVEL2_GROUPS   = 2;
    localparam int unsigned P_LEVEL3_GROUPS   = 2;
    localparam int unsigned P_SLOTS_PER_GROUP = 32;

    // Fixed field widths.
    localparam int unsigned TICK_W  = 16;
    localparam int unsigned ENTRY_W = 3 * TICK_W;

    typedef enum logic [1:0] {
        ACT_TICK = 2'd0,
        ACT_ADD  = 2'd1,
        ACT_DEL  = 2'd2,
        ACT_NOP  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_LEVEL = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_READ,
        S_EVAL,
        S_RESP
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;
        logic    tick_inc;
        logic    set_status;
        t_status status;
        logic    grp_init;
        logic    grp_inc;
        logic    rd_en;
        logic    commit;
        logic    out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_tick;
        logic is_nop;
        logic is_add;
        logic lvl_bad;
        logic grp_end;
        logic hit;
    } t_sts;

endpackage

// ----- hdl/priority_task_slot_table.sv -----
// Top level of the priority task slot table: stream ports, controller and datapath.
//
// Channel   Direction  Payload
// s_axis    in         tuser: action[1:0]; tdata: level, task_id, period, start_offset
// m_axis    out        tuser: status[1:0]; tdata: group_index, slot_index, tick_now
//
// One item is worked at a time. A tick, a no-op or a bad level passes decode to the response
// state; add and delete pass decode, then a read and an evaluation per group walked, plus a
// final read when no group of the level yields a slot. The input is ready again only once the
// result is in the output register. The walk reads one row of the slot memory per group.
// The slot memory needs no clearing: only the entries of occupied slots are ever used.
// Reset is synchronous and active low; it clears the tick counter and all slot masks.
// A stalled result is held in the output register; the next item is taken meanwhile.
`timescale 1ns / 1ps
module priority_task_slot_table
    import ptst_pkg::*;
#(
    parameter int unsigned LEVEL0_GROUPS   = P_LEVEL0_GROUPS,
    parameter int unsigned LEVEL1_GROUPS   = P_LEVEL1_GROUPS,
    parameter int unsigned LEVEL2_GROUPS   = P_LEVEL2_GROUPS,
    parameter int unsigned LEVEL3_GROUPS   = P_LEVEL3_GROUPS,
    parameter int unsigned SLOTS_PER_GROUP = P_SLOTS_PER_GROUP
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // level[2:0], task_id[18:3], period[34:19], start_offset[50:35], zero pad
    input  logic [55:0] i_s_axis_tdata,
    // action[1:0]
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // group_index[2:0], slot_index[7:3], tick_now[23:8]
    output logic [23:0] o_m_axis_tdata,
    // status[1:0]
    output logic [1:0]  o_m_axis_tuser
);

    t_cmd        cmd;
    t_sts        sts;
    logic [2:0]  grp;
    logic [4:0]  slot;
    logic [15:0] tick;

    ptst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    ptst_dp #(
        .LEVEL0_GROUPS   (LEVEL0_GROUPS),
        .LEVEL1_GROUPS   (LEVEL1_GROUPS),
        .LEVEL2_GROUPS   (LEVEL2_GROUPS),
        .LEVEL3_GROUPS   (LEVEL3_GROUPS),
        .SLOTS_PER_GROUP (SLOTS_PER_GROUP)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_action       (i_s_axis_tuser),
        .i_level        (i_s_axis_tdata[2:0]),
        .i_task_id      (i_s_axis_tdata[18:3]),
        .i_period       (i_s_axis_tdata[34:19]),
        .i_start_offset (i_s_axis_tdata[50:35]),
        .o_status       (o_m_axis_tuser),
        .o_group_index  (grp),
        .o_slot_index   (slot),
        .o_tick_now     (tick)
    );

    assign o_m_axis_tdata = {tick, slot, grp};

endmodule

// ----- hdl/ptst_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module ptst_ram
#(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/ptst_ctrl.sv -----
// Controller state machine of the priority task slot table.
`timescale 1ns / 1ps
module ptst_ctrl
    import ptst_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    t_cmd   cmd;

    // State and output valid registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        cmd.status = ST_OK;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.is_tick) begin
                    cmd.tick_inc   = 1'b1;
                    cmd.set_status = 1'b1;
                    n_state        = S_RESP;
                end else if (i_sts.is_nop) begin
                    cmd.set_status = 1'b1;
                    n_state        = S_RESP;
                end else if (i_sts.lvl_bad) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_BAD_LEVEL;
                    n_state        = S_RESP;
                end else begin
                    cmd.grp_init = 1'b1;
                    n_state      = S_READ;
                end
            end
            S_READ: begin
                if (i_sts.grp_end) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = i_sts.is_add ? ST_FULL : ST_NOT_FOUND;
                    n_state        = S_RESP;
                end else begin
                    cmd.rd_en = 1'b1;
                    n_state   = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_sts.hit) begin
                    cmd.commit = 1'b1;
                    n_state    = S_RESP;
                end else begin
                    cmd.grp_inc = 1'b1;
                    n_state     = S_READ;
                end
            end
            S_RESP: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Result valid: set on load, cleared when the transaction completes.
    always_comb begin
        n_out_valid = r_out_valid;
        if (cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_cmd       = cmd;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_DECODE))
        else $error("accepted item did not enter decode");

    a_eval_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL) |-> ($past(r_state) == S_READ))
        else $error("evaluation without a preceding read");

    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |=> r_out_valid)
        else $error("result load did not raise valid");

endmodule

// ----- hdl/ptst_dp.sv -----
// Datapath of the priority task slot table: masks, slot memory, tick counter and result.
`timescale 1ns / 1ps
module ptst_dp
    import ptst_pkg::*;
#(
    parameter int unsigned LEVEL0_GROUPS   = P_LEVEL0_GROUPS,
    parameter int unsigned LEVEL1_GROUPS   = P_LEVEL1_GROUPS,
    parameter int unsigned LEVEL2_GROUPS   = P_LEVEL2_GROUPS,
    parameter int unsigned LEVEL3_GROUPS   = P_LEVEL3_GROUPS,
    parameter int unsigned SLOTS_PER_GROUP = P_SLOTS_PER_GROUP
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic [1:0]  i_action,
    input  logic [2:0]  i_level,
    input  logic [15:0] i_task_id,
    input  logic [15:0] i_period,
    input  logic [15:0] i_start_offset,
    output logic [1:0]  o_status,
    output logic [2:0]  o_group_index,
    output logic [4:0]  o_slot_index,
    output logic [15:0] o_tick_now
);

    localparam int unsigned TOTAL = LEVEL0_GROUPS + LEVEL1_GROUPS
                                  + LEVEL2_GROUPS + LEVEL3_GROUPS;
    localparam int unsigned GW    = $clog2(TOTAL + 1);
    localparam int unsigned AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int unsigned SW    = (SLOTS_PER_GROUP > 1) ? $clog2(SLOTS_PER_GROUP) : 1;
    localparam int unsigned ROW_W = SLOTS_PER_GROUP * ENTRY_W;
    localparam int unsigned L2F   = LEVEL3_GROUPS;
    localparam int unsigned L1F   = L2F + LEVEL2_GROUPS;
    localparam int unsigned L0F   = L1F + LEVEL1_GROUPS;

    // Latched item.
    t_action     r_action;
    logic [2:0]  r_level;
    logic [15:0] r_id, r_period, r_ofs;

    logic [TICK_W-1:0] r_tick;
    logic [GW-1:0]     r_grp, r_end;
    logic [GW-1:0]     first_grp, end_grp;

    logic [SLOTS_PER_GROUP-1:0] r_occ   [TOTAL];
    logic [SLOTS_PER_GROUP-1:0] r_unst  [TOTAL];
    logic [SLOTS_PER_GROUP-1:0] r_act   [TOTAL];

    // Result register.
    t_status     r_status;
    logic [2:0]  r_grp_out;
    logic [4:0]  r_slot_out;
    t_status     r_res_status;
    logic [2:0]  r_res_grp;
    logic [4:0]  r_res_slot;
    logic [15:0] r_res_tick;

    logic [ROW_W-1:0]           rdata, wdata;
    logic [SLOTS_PER_GROUP-1:0] occ_row, hit_vec;
    logic [SW-1:0]              sel;
    logic [AW-1:0]              gaddr;
    logic [ENTRY_W-1:0]         new_entry;
    logic                       we;

    assign gaddr = r_grp[AW-1:0];

    // Group range of the latched level.
    always_comb begin
        case (r_level[1:0])
            2'd3:    begin first_grp = GW'(0);   end_grp = GW'(LEVEL3_GROUPS); end
            2'd2:    begin first_grp = GW'(L2F); end_grp = GW'(L1F);           end
            2'd1:    begin first_grp = GW'(L1F); end_grp = GW'(L0F);           end
            default: begin first_grp = GW'(L0F); end_grp = GW'(TOTAL);         end
        endcase
    end

    // Hit vector: free slots for add, occupied slots holding the id for delete.
    always_comb begin
        occ_row = r_occ[gaddr];
        for (int s = 0; s < SLOTS_PER_GROUP; s++) begin
            if (r_action == ACT_ADD) begin
                hit_vec[s] = !occ_row[s];
            end else begin
                hit_vec[s] = occ_row[s] && (rdata[s*ENTRY_W +: TICK_W] == r_id);
            end
        end
    end

    // Lowest set bit of the hit vector.
    always_comb begin
        sel = '0;
        for (int s = SLOTS_PER_GROUP - 1; s >= 0; s--) begin
            if (hit_vec[s]) begin
                sel = SW'(s);
            end
        end
    end

    // Row merge for an add: the chosen slot takes the new entry.
    always_comb begin
        new_entry = {r_tick + r_ofs, r_period, r_id};
        for (int s = 0; s < SLOTS_PER_GROUP; s++) begin
            if (SW'(s) == sel) begin
                wdata[s*ENTRY_W +: ENTRY_W] = new_entry;
            end else begin
                wdata[s*ENTRY_W +: ENTRY_W] = rdata[s*ENTRY_W +: ENTRY_W];
            end
        end
    end

    assign we = i_cmd.commit && (r_action == ACT_ADD);

    ptst_ram #(
        .WIDTH (ROW_W),
        .DEPTH (TOTAL)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (gaddr),
        .i_wdata (wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (gaddr),
        .o_rdata (rdata)
    );

    // Item latch and group walk.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= t_action'(i_action);
            r_level  <= i_level;
            r_id     <= i_task_id;
            r_period <= i_period;
            r_ofs    <= i_start_offset;
        end
        if (i_cmd.grp_init) begin
            r_grp <= first_grp;
            r_end <= end_grp;
        end else if (i_cmd.grp_inc) begin
            r_grp <= r_grp + GW'(1);
        end
    end

    // Tick counter and slot masks.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick <= '0;
            for (int g = 0; g < TOTAL; g++) begin
                r_occ[g]  <= '0;
                r_unst[g] <= '0;
                r_act[g]  <= '0;
            end
        end else begin
            if (i_cmd.tick_inc) begin
                r_tick <= r_tick + TICK_W'(1);
            end
            if (i_cmd.commit) begin
                if (r_action == ACT_ADD) begin
                    r_occ[gaddr][sel] <= 1'b1;
                    if (r_level[1:0] != 2'd0) begin
                        r_unst[gaddr][sel] <= 1'b1;
                    end
                end else begin
                    r_occ[gaddr][sel] <= 1'b0;
                    r_act[gaddr][sel] <= 1'b0;
                end
            end
        end
    end

    // Working result and output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.set_status) begin
            r_status   <= i_cmd.status;
            r_grp_out  <= '0;
            r_slot_out <= '0;
        end else if (i_cmd.commit) begin
            r_status   <= ST_OK;
            r_grp_out  <= 3'(r_grp);
            r_slot_out <= 5'(sel);
        end
        if (i_cmd.out_load) begin
            r_res_status <= r_status;
            r_res_grp    <= r_grp_out;
            r_res_slot   <= r_slot_out;
            r_res_tick   <= r_tick;
        end
    end

    assign o_sts.is_tick = (r_action == ACT_TICK);
    assign o_sts.is_nop  = (r_action == ACT_NOP);
    assign o_sts.is_add  = (r_action == ACT_ADD);
    assign o_sts.lvl_bad = r_level[2];
    assign o_sts.grp_end = (r_grp == r_end);
    assign o_sts.hit     = |hit_vec;

    assign o_status      = r_res_status;
    assign o_group_index = r_res_grp;
    assign o_slot_index  = r_res_slot;
    assign o_tick_now    = r_res_tick;

    // Commits stay within the level's groups; unstarted bits are only ever set by an add.
    a_unst_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> (r_grp < r_end))
        else $error("commit outside the level's groups");

    a_tick_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.tick_inc |=> (r_tick == $past(r_tick) + TICK_W'(1)))
        else $error("tick counter did not advance");

    a_active_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_action == ACT_DEL) |=> !r_occ[$past(gaddr)][$past(sel)])
        else $error("delete left the slot occupied");

endmodule

// ----- tb/priority_task_slot_table_tb.sv -----
// Self-checking testbench of the priority task slot table.
`timescale 1ns / 1ps
module priority_task_slot_table_tb;
    import ptst_pkg::*;

    localparam int unsigned N_GROUPS   = 8;
    localparam int unsigned N_SLOTS    = 32;
    localparam int unsigned N_RANDOM   = 620;
    localparam int unsigned DRAIN_CYC  = 64;

    // One input transaction and one expected response.
    typedef struct packed {
        t_action     act;
        logic [2:0]  level;
        logic [15:0] task_id;
        logic [15:0] period;
        logic [15:0] offset;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [2:0]  grp;
        logic [4:0]  slot;
        logic [15:0] tick;
    } t_rsp;

    // Directed row: request plus an optional typed-in expectation.
    typedef struct packed {
        t_req req;
        logic fixed;
        t_rsp rsp;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;

    priority_task_slot_table uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    // Predictor state of the task table.
    logic [15:0] tbl_tick;
    logic [31:0] tbl_occ [N_GROUPS];
    logic [15:0] tbl_id  [N_GROUPS][N_SLOTS];

    t_rsp rsp_pending[$];
    int   err_count;
    bit   stall_hold;
    bit   hold_go;
    bit   no_idle;

    // Clock generation.
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Compute the response of one request and update the table copy.
    function automatic t_rsp table_apply(t_req r);
        t_rsp res;
        int   first;
        int   g;
        int   s;
        bit   done;
        res = '{status: ST_OK, grp: 3'd0, slot: 5'd0, tick: 16'd0};
        first = 0;
        done = 1'b0;
        if (r.act == ACT_TICK) begin
            tbl_tick = tbl_tick + 16'd1;
        end else if (r.act == ACT_ADD || r.act == ACT_DEL) begin
            if (r.level > 3'd3) begin
                res.status = ST_BAD_LEVEL;
            end else begin
                // Level 3 groups come first, level 0 last.
                first = 2 * (3 - int'(r.level));
                res.status = (r.act == ACT_ADD) ? ST_FULL : ST_NOT_FOUND;
                for (g = first; g < first + 2 && !done; g++) begin
                    for (s = 0; s < N_SLOTS && !done; s++) begin
                        if (r.act == ACT_ADD && !tbl_occ[g][s]) begin
                            tbl_occ[g][s] = 1'b1;
                            tbl_id[g][s] = r.task_id;
                            done = 1'b1;
                        end else if (r.act == ACT_DEL && tbl_occ[g][s]
                                     && tbl_id[g][s] == r.task_id) begin
                            tbl_occ[g][s] = 1'b0;
                            done = 1'b1;
                        end
                        if (done) begin
                            res.status = ST_OK;
                            res.grp = g[2:0];
                            res.slot = s[4:0];
                        end
                    end
                end
            end
        end
        res.tick = tbl_tick;
        return res;
    endfunction

    // Offer one transaction and wait for acceptance, with random gaps.
    task automatic send_req(t_req r, t_rsp fixed_rsp, bit use_fixed);
        t_rsp pred;
        if (!no_idle) begin
            while ($urandom_range(99) < 29) begin
                s_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.act;
        s_tdata  <= {5'd0, r.offset, r.period, r.task_id, r.level};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        pred = table_apply(r);
        if (use_fixed && pred != fixed_rsp) begin
            $display("%0t: directed row disagrees with predictor exp=%h got=%h",
                     $time, fixed_rsp, pred);
            err_count++;
        end
        rsp_pending.push_back(use_fixed ? fixed_rsp : pred);
    endtask

    task automatic send_idle_wait();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (rsp_pending.size() != 0) @(posedge i_clk);
    endtask

    // Random request; mostly adds and deletes over a small id pool.
    function automatic t_req rand_req();
        t_req r;
        int   k;
        k = $urandom_range(99);
        r.level   = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(3));
        r.task_id = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(40));
        r.period  = 16'($urandom);
        r.offset  = 16'($urandom);
        if (k < 20)      r.act = ACT_TICK;
        else if (k < 60) r.act = ACT_ADD;
        else if (k < 97) r.act = ACT_DEL;
        else             r.act = ACT_NOP;
        return r;
    endfunction

    // Result side: random stalls, one long hold-off, compare each transaction.
    always @(posedge i_clk) begin
        t_rsp got;
        t_rsp exp;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = '{status: t_status'(m_tuser), grp: m_tdata[2:0],
                        slot: m_tdata[7:3], tick: m_tdata[23:8]};
                if (rsp_pending.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    err_count++;
                end else begin
                    exp = rsp_pending.pop_front();
                    if (got.status != exp.status || got.grp != exp.grp
                        || got.slot != exp.slot || got.tick != exp.tick) begin
                        $display("%0t: mismatch exp st=%0d g=%0d s=%0d t=%0d got st=%0d g=%0d s=%0d t=%0d",
                                 $time, exp.status, exp.grp, exp.slot, exp.tick,
                                 got.status, got.grp, got.slot, got.tick);
                        err_count++;
                    end
                end
            end
            m_tready <= !stall_hold && (no_idle || $urandom_range(99) >= 29);
        end
    end

    // Long receiver hold-off, counted in its own process, while the sender keeps offering.
    initial begin
        int n;
        stall_hold = 1'b0;
        wait (hold_go);
        stall_hold = 1'b1;
        for (n = 0; n < 400; n++) @(posedge i_clk);
        stall_hold = 1'b0;
    end

    // Run limit.
    initial begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

    // Stimulus.
    initial begin
        t_row rows[$];
        t_req r;
        t_rsp none;
        int   i;
        int   g;
        err_count = 0;
        no_idle   = 1'b0;
        hold_go   = 1'b0;
        none      = '0;
        tbl_tick  = 16'd0;
        for (g = 0; g < N_GROUPS; g++) tbl_occ[g] = 32'd0;
        i_rst_n  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= ACT_TICK;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows: reset values, extremes and error codes.
        rows.push_back('{'{ACT_TICK, 3'd0, 16'd0, 16'd0, 16'd0}, 1'b1,
                         '{ST_OK, 3'd0, 5'd0, 16'd1}});
        rows.push_back('{'{ACT_DEL, 3'd0, 16'hFFFF, 16'd0, 16'd0}, 1'b1,
                         '{ST_NOT_FOUND, 3'd0, 5'd0, 16'd1}});
        rows.push_back('{'{ACT_ADD, 3'd7, 16'd1, 16'hFFFF, 16'hFFFF}, 1'b1,
                         '{ST_BAD_LEVEL, 3'd0, 5'd0, 16'd1}});
        rows.push_back('{'{ACT_DEL, 3'd4, 16'd1, 16'd0, 16'd0}, 1'b1,
                         '{ST_BAD_LEVEL, 3'd0, 5'd0, 16'd1}});
        rows.push_back('{'{ACT_NOP, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1,
                         '{ST_OK, 3'd0, 5'd0, 16'd1}});
        rows.push_back('{'{ACT_ADD, 3'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1,
                         '{ST_OK, 3'd0, 5'd0, 16'd1}});
        rows.push_back('{'{ACT_ADD, 3'd0, 16'h0000, 16'h0000, 16'h0000}, 1'b1,
                         '{ST_OK, 3'd6, 5'd0, 16'd1}});
        rows.push_back('{'{ACT_ADD, 3'd2, 16'hA5A5, 16'h5A5A, 16'h1234}, 1'b0, none});
        rows.push_back('{'{ACT_ADD, 3'd1, 16'h5A5A, 16'h0001, 16'h8000}, 1'b0, none});
        rows.push_back('{'{ACT_ADD, 3'd3, 16'hFFFF, 16'd7, 16'd9}, 1'b0, none});
        rows.push_back('{'{ACT_DEL, 3'd3, 16'hFFFF, 16'd0, 16'd0}, 1'b0, none});
        rows.push_back('{'{ACT_DEL, 3'd0, 16'h0000, 16'd0, 16'd0}, 1'b0, none});
        rows.push_back('{'{ACT_DEL, 3'd2, 16'hA5A5, 16'd0, 16'd0}, 1'b0, none});
        rows.push_back('{'{ACT_DEL, 3'd2, 16'hA5A5, 16'd0, 16'd0}, 1'b0, none});
        for (i = 0; i < rows.size(); i++) send_req(rows[i].req, rows[i].rsp, rows[i].fixed);

        // Fill level 1 past both groups to reach the full status.
        for (i = 0; i < 66; i++) begin
            r = '{ACT_ADD, 3'd1, 16'(i + 100), 16'($urandom), 16'($urandom)};
            send_req(r, none, 1'b0);
        end
        // Sender pause until every response is back.
        send_idle_wait();
        // Free a slot in the second group and refill it.
        send_req('{ACT_DEL, 3'd1, 16'd150, 16'd0, 16'd0}, none, 1'b0);
        send_req('{ACT_ADD, 3'd1, 16'd7, 16'd0, 16'd0}, none, 1'b0);

        // Random part, with a stretch without idling in the middle.
        for (i = 0; i < N_RANDOM; i++) begin
            no_idle = (i >= 300 && i < 400);
            if (i == 150) hold_go = 1'b1;
            send_req(rand_req(), none, 1'b0);
        end
        no_idle = 1'b0;
        s_tvalid <= 1'b0;

        i = 0;
        while (rsp_pending.size() != 0 && i < 100000) begin
            @(posedge i_clk);
            i++;
        end
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (err_count == 0 && rsp_pending.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
